@@ src/eta_pkg.sv @@
// ----------------------------------------------------------------------------
// eta_pkg
// Shared types, widths, codes and the ease table builder for the animator.
// ----------------------------------------------------------------------------
package eta_pkg;

    // Field widths
    localparam int REQ_W      = 2;
    localparam int TIME_W     = 32;
    localparam int DELTA_W    = 16;
    localparam int VALUE_W    = 24;
    localparam int FRAME_W    = 8;
    localparam int PROG_W     = 17;
    localparam int SPEED_W    = 11;
    localparam int CNT_W      = 9;
    localparam int INTV_W     = 16;
    localparam int EASE_W     = 16;

    // Stream packing
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 56;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_VALUE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTV  = 3'd6;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TOGGLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET  = 2'd2;

    // Register reset values
    localparam logic [SPEED_W-1:0] SPEED_RST = 11'd256;
    localparam logic [CNT_W-1:0]   COUNT_RST = 9'd8;
    localparam logic [INTV_W-1:0]  INTV_RST  = 16'd125;

    // Parameter defaults
    localparam int DEF_EASE_TABLE_DEPTH = 256;
    localparam int DEF_MAX_FRAMES       = 256;

    // Fixed point constants
    localparam logic [PROG_W-1:0] PROG_ONE    = 17'h10000;
    localparam longint            HALF_PI_Q30 = 64'sd1686629713;
    // floor(2^38 / 125): progress step divide by 1000 after the x256 shift
    localparam logic [31:0]       RECIP_125   = 32'd2199023255;
    localparam int                RECIP_SHIFT = 38;
    localparam logic [6:0]        DIV_125     = 7'd125;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FR_MUL,
        ST_FR_CHECK,
        ST_FR_DIV,
        ST_FR_COMMIT,
        ST_TW_MUL1,
        ST_TW_MUL2,
        ST_TW_CORR1,
        ST_TW_CORR2,
        ST_EW_POS,
        ST_EW_RDLO,
        ST_EW_RDHI,
        ST_EW_INTERP,
        ST_EW_WEIGHT,
        ST_VL_MUL,
        ST_VL_SUM,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic toggle;
        logic clear;
        logic fr_mul;
        logic div_start;
        logic div_step;
        logic fr_commit;
        logic tw_mul1;
        logic tw_mul2;
        logic tw_corr1;
        logic tw_corr2;
        logic ew_pos;
        logic rd_lo;
        logic rd_hi;
        logic ew_interp;
        logic ew_weight;
        logic vl_mul;
        logic vl_sum;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             playing;
        logic             frame_mode;
        logic             advance;
        logic             div_last;
    } status_t;

    // Ease of an angle a (Q30 radians, up to pi/4): sine series squared, Q0.16
    function automatic longint ease_low(longint a);
        longint a2;
        longint a3;
        longint a5;
        longint a7;
        longint s;
        longint s2;
        a2 = (a * a) >>> 30;
        a3 = (a2 * a) >>> 30;
        a5 = (a3 * a2) >>> 30;
        a7 = (a5 * a2) >>> 30;
        s  = a - a3 / 6 + a5 / 120 - a7 / 5040;
        if (s < 0) begin
            s = 0;
        end
        s2 = (s * s) >>> 30;
        return (s2 + 8192) >>> 14;
    endfunction

endpackage

@@ src/eta_ctrl.sv @@
// ----------------------------------------------------------------------------
// eta_ctrl
// Sequencer: steps one item through the datapath and owns the stream flags.
// ----------------------------------------------------------------------------
module eta_ctrl
    import eta_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.req == REQ_TICK && status.playing) begin
                    state_next = status.frame_mode ? ST_FR_MUL : ST_TW_MUL1;
                end else begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_FR_MUL:    state_next = ST_FR_CHECK;
            ST_FR_CHECK:  state_next = status.advance ? ST_FR_DIV : ST_PUBLISH;
            ST_FR_DIV: begin
                if (status.div_last) begin
                    state_next = ST_FR_COMMIT;
                end
            end
            ST_FR_COMMIT: state_next = ST_PUBLISH;
            ST_TW_MUL1:   state_next = ST_TW_MUL2;
            ST_TW_MUL2:   state_next = ST_TW_CORR1;
            ST_TW_CORR1:  state_next = ST_TW_CORR2;
            ST_TW_CORR2:  state_next = ST_EW_POS;
            ST_EW_POS:    state_next = ST_EW_RDLO;
            ST_EW_RDLO:   state_next = ST_EW_RDHI;
            ST_EW_RDHI:   state_next = ST_EW_INTERP;
            ST_EW_INTERP: state_next = ST_EW_WEIGHT;
            ST_EW_WEIGHT: state_next = ST_VL_MUL;
            ST_VL_MUL:    state_next = ST_VL_SUM;
            ST_VL_SUM:    state_next = ST_PUBLISH;
            ST_PUBLISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:      cmd.load_in = s_tvalid;
            ST_DECODE: begin
                cmd.toggle = (status.req == REQ_TOGGLE);
                cmd.clear  = (status.req == REQ_RESET);
            end
            ST_FR_MUL:    cmd.fr_mul = 1'b1;
            ST_FR_CHECK:  cmd.div_start = 1'b1;
            ST_FR_DIV:    cmd.div_step = 1'b1;
            ST_FR_COMMIT: cmd.fr_commit = 1'b1;
            ST_TW_MUL1:   cmd.tw_mul1 = 1'b1;
            ST_TW_MUL2:   cmd.tw_mul2 = 1'b1;
            ST_TW_CORR1:  cmd.tw_corr1 = 1'b1;
            ST_TW_CORR2:  cmd.tw_corr2 = 1'b1;
            ST_EW_POS:    cmd.ew_pos = 1'b1;
            ST_EW_RDLO:   cmd.rd_lo = 1'b1;
            ST_EW_RDHI:   cmd.rd_hi = 1'b1;
            ST_EW_INTERP: cmd.ew_interp = 1'b1;
            ST_EW_WEIGHT: cmd.ew_weight = 1'b1;
            ST_VL_MUL:    cmd.vl_mul = 1'b1;
            ST_VL_SUM:    cmd.vl_sum = 1'b1;
            ST_PUBLISH:   cmd.publish = out_free;
            default:      cmd = '0;
        endcase
    end

    always_comb begin
        if (cmd.publish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

endmodule

@@ src/eta_datapath.sv @@
// ----------------------------------------------------------------------------
// eta_datapath
// Configuration, channel state, shared arithmetic and the result register.
// ----------------------------------------------------------------------------
module eta_datapath
    import eta_pkg::*;
#(
    parameter int EASE_TABLE_DEPTH = DEF_EASE_TABLE_DEPTH,
    parameter int MAX_FRAMES       = DEF_MAX_FRAMES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  cmd_t                  cmd,
    output status_t               status
);

    localparam int FIDX_W = $clog2(MAX_FRAMES);
    localparam int ND     = FIDX_W + 1;
    localparam int DCNT_W = $clog2(ND);
    localparam int AW     = (EASE_TABLE_DEPTH > 1) ? $clog2(EASE_TABLE_DEPTH) : 1;
    localparam int POS_W  = PROG_W + $clog2(EASE_TABLE_DEPTH + 1);
    localparam int IW     = POS_W - 16;
    localparam int FPR_W  = TIME_W + SPEED_W;
    localparam int TPR_W  = DELTA_W + SPEED_W;
    localparam int N_W    = TPR_W + 5;
    localparam int Q_W    = 2 * N_W - RECIP_SHIFT;
    localparam int SUM_W  = Q_W + 1;
    localparam int D_W    = VALUE_W + 1;
    localparam int X_W    = D_W + PROG_W + 1;
    localparam int V_W    = X_W - 16;

    // configuration
    logic                        frame_mode_reg;
    logic                        loop_reg;
    logic [SPEED_W-1:0]          speed_reg;
    logic [VALUE_W-1:0]          start_reg;
    logic [VALUE_W-1:0]          end_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [INTV_W-1:0]           intv_reg;

    // channel state
    logic [PROG_W-1:0]           progress_reg;
    logic [PROG_W-1:0]           progress_next;
    logic [FIDX_W-1:0]           idx_reg;
    logic [FIDX_W-1:0]           idx_next;
    logic [TIME_W-1:0]           last_reg;
    logic [TIME_W-1:0]           last_next;
    logic                        play_reg;
    logic                        play_next;
    logic [VALUE_W-1:0]          value_reg;
    logic [VALUE_W-1:0]          value_next;

    // working registers
    logic [REQ_W-1:0]            req_reg;
    logic [TIME_W-1:0]           time_reg;
    logic [DELTA_W-1:0]          delta_reg;
    logic [FPR_W-1:0]            fprod_reg;
    logic [ND-1:0]               dvd_reg;
    logic [CNT_W:0]              rem_reg;
    logic [CNT_W-1:0]            div_reg;
    logic [DCNT_W-1:0]           dcnt_reg;
    logic [TPR_W-1:0]            tprod_reg;
    logic [Q_W-1:0]              q0_reg;
    logic                        rge_reg;
    logic signed [D_W-1:0]       d_reg;
    logic [IW-1:0]               i_reg;
    logic [15:0]                 f_reg;
    logic [EASE_W-1:0]           rom_q_reg;
    logic [EASE_W-1:0]           lo_reg;
    logic [2*PROG_W-1:0]         imul_reg;
    logic [PROG_W-1:0]           w_reg;
    logic signed [X_W-1:0]       x_reg;
    logic [M_TDATA_W-1:0]        m_tdata_reg;

    // combinational helpers
    logic [CNT_W-1:0]            count_eff;
    logic [TIME_W-1:0]           elapsed_val;
    logic [N_W-1:0]              n_val;
    logic [2*N_W-1:0]            rprod;
    logic [N_W:0]                q125;
    logic [N_W:0]                r_val;
    logic [SUM_W-1:0]            sum_val;
    logic [CNT_W:0]              rem_sh;
    logic [POS_W-1:0]            pos_val;
    logic [IW-1:0]               rd_idx;
    logic [AW-1:0]               rom_addr;
    logic [PROG_W-1:0]           hi_val;
    logic [PROG_W-1:0]           lo_ext;
    logic [PROG_W-1:0]           diff_val;
    logic signed [X_W-1:0]       x_rnd;
    logic signed [V_W-1:0]       q_val;

    // ease table, built at elaboration
    logic [EASE_W-1:0]           ease_rom [EASE_TABLE_DEPTH];

    for (genvar g = 0; g < EASE_TABLE_DEPTH; g++) begin : g_ease
        localparam bit     UPPER = (2 * g > EASE_TABLE_DEPTH);
        localparam longint K     = UPPER ? longint'(EASE_TABLE_DEPTH - g) : longint'(g);
        localparam longint A     = (K * HALF_PI_Q30) / EASE_TABLE_DEPTH;
        localparam longint E     = UPPER ? 65536 - ease_low(A) : ease_low(A);
        localparam longint EC    = (E > 65535) ? 65535 : E;
        assign ease_rom[g] = EASE_W'(EC);
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_mode_reg <= 1'b0;
            loop_reg       <= 1'b1;
            speed_reg      <= SPEED_RST;
            start_reg      <= '0;
            end_reg        <= '0;
            count_reg      <= COUNT_RST;
            intv_reg       <= INTV_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_FRAME_MODE:  frame_mode_reg <= cfg_wr_data[0];
                CFG_LOOP_ENABLE: loop_reg       <= cfg_wr_data[0];
                CFG_SPEED:       speed_reg      <= cfg_wr_data[SPEED_W-1:0];
                CFG_START_VALUE: start_reg      <= cfg_wr_data[VALUE_W-1:0];
                CFG_END_VALUE:   end_reg        <= cfg_wr_data[VALUE_W-1:0];
                CFG_FRAME_COUNT: count_reg      <= cfg_wr_data[CNT_W-1:0];
                CFG_FRAME_INTV:  intv_reg       <= cfg_wr_data[INTV_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp frame count to 1 .. MAX_FRAMES
    always_comb begin
        if (count_reg == '0) begin
            count_eff = CNT_W'(1);
        end else if (32'(count_reg) > 32'(MAX_FRAMES)) begin
            count_eff = CNT_W'(MAX_FRAMES);
        end else begin
            count_eff = count_reg;
        end
    end

    // elapsed time wraps with the millisecond clock
    assign elapsed_val = time_reg - last_reg;

    // tween step: floor(delta * speed * 256 / 1000) = floor(n / 125)
    assign n_val   = {tprod_reg, 5'b0};
    assign rprod   = (2*N_W)'(n_val) * (2*N_W)'(RECIP_125);
    assign q125    = (N_W+1)'(q0_reg) * (N_W+1)'(DIV_125);
    assign r_val   = {1'b0, n_val} - q125;
    assign sum_val = SUM_W'(progress_reg) + SUM_W'(q0_reg) + SUM_W'(rge_reg);

    // one restoring step of the frame remainder
    assign rem_sh  = {rem_reg[CNT_W-1:0], dvd_reg[ND-1]};

    assign pos_val = POS_W'(progress_reg) * POS_W'(EASE_TABLE_DEPTH);

    always_comb begin
        rd_idx = cmd.rd_hi ? i_reg + IW'(1) : i_reg;
        if (rd_idx < IW'(EASE_TABLE_DEPTH)) begin
            rom_addr = AW'(rd_idx);
        end else begin
            rom_addr = '0;
        end
    end

    assign lo_ext   = {1'b0, lo_reg};
    assign hi_val   = ((i_reg + IW'(1)) < IW'(EASE_TABLE_DEPTH)) ? {1'b0, rom_q_reg} : PROG_ONE;
    assign diff_val = (hi_val > lo_ext) ? hi_val - lo_ext : '0;

    // round half up, then floor by the arithmetic shift
    assign x_rnd = x_reg + X_W'(32768);
    assign q_val = V_W'(x_rnd >>> 16);

    // channel state update
    always_comb begin
        progress_next = progress_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        play_next     = play_reg;
        value_next    = value_reg;
        if (cmd.toggle) begin
            play_next = !play_reg;
        end
        if (cmd.clear) begin
            progress_next = '0;
            idx_next      = '0;
        end
        if (cmd.fr_commit) begin
            idx_next  = FIDX_W'(rem_reg);
            last_next = time_reg;
            if (rem_reg == '0 && !loop_reg) begin
                play_next = 1'b0;
            end
        end
        if (cmd.tw_corr2) begin
            if (sum_val >= SUM_W'(PROG_ONE)) begin
                if (loop_reg) begin
                    progress_next = {1'b0, sum_val[15:0]};
                end else begin
                    progress_next = PROG_ONE;
                    play_next     = 1'b0;
                end
            end else begin
                progress_next = PROG_W'(sum_val);
            end
        end
        if (cmd.vl_sum) begin
            value_next = VALUE_W'(V_W'($signed(start_reg)) + q_val);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            progress_reg <= '0;
            idx_reg      <= '0;
            last_reg     <= '0;
            play_reg     <= 1'b1;
            value_reg    <= '0;
        end else begin
            progress_reg <= progress_next;
            idx_reg      <= idx_next;
            last_reg     <= last_next;
            play_reg     <= play_next;
            value_reg    <= value_next;
        end
    end

    // arithmetic pipeline registers, each loaded only under its own commands
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            req_reg   <= s_tuser[REQ_W-1:0];
            time_reg  <= s_tdata[TIME_W-1:0];
            delta_reg <= s_tdata[TIME_W +: DELTA_W];
        end
        if (cmd.fr_mul) begin
            fprod_reg <= FPR_W'(elapsed_val) * FPR_W'(speed_reg);
        end
        if (cmd.div_start) begin
            dvd_reg  <= ND'(idx_reg) + ND'(1);
            rem_reg  <= '0;
            div_reg  <= count_eff;
            dcnt_reg <= DCNT_W'(ND - 1);
        end
        if (cmd.div_step) begin
            dvd_reg  <= {dvd_reg[ND-2:0], 1'b0};
            rem_reg  <= (rem_sh >= {1'b0, div_reg}) ? rem_sh - {1'b0, div_reg} : rem_sh;
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
        if (cmd.tw_mul1) begin
            tprod_reg <= TPR_W'(delta_reg) * TPR_W'(speed_reg);
            d_reg     <= D_W'($signed(end_reg)) - D_W'($signed(start_reg));
        end
        if (cmd.tw_mul2) begin
            q0_reg <= rprod[2*N_W-1:RECIP_SHIFT];
        end
        if (cmd.tw_corr1) begin
            rge_reg <= (r_val >= (N_W+1)'(DIV_125));
        end
        if (cmd.ew_pos) begin
            i_reg <= pos_val[POS_W-1:16];
            f_reg <= pos_val[15:0];
        end
        if (cmd.rd_lo || cmd.rd_hi) begin
            rom_q_reg <= ease_rom[rom_addr];
        end
        if (cmd.rd_hi) begin
            lo_reg <= rom_q_reg;
        end
        if (cmd.ew_interp) begin
            imul_reg <= (2*PROG_W)'(diff_val) * (2*PROG_W)'(f_reg);
        end
        if (cmd.ew_weight) begin
            if (i_reg >= IW'(EASE_TABLE_DEPTH)) begin
                w_reg <= PROG_ONE;
            end else begin
                w_reg <= lo_ext + PROG_W'(imul_reg >> 16);
            end
        end
        if (cmd.vl_mul) begin
            x_reg <= X_W'(d_reg) * X_W'($signed({1'b0, w_reg}));
        end
        if (cmd.publish) begin
            m_tdata_reg <= M_TDATA_W'({progress_next, play_next,
                                       FRAME_W'({{FRAME_W{1'b0}}, idx_next}),
                                       value_next});
        end
    end

    assign m_tdata = m_tdata_reg;

    assign status.req        = req_reg;
    assign status.playing    = play_reg;
    assign status.frame_mode = frame_mode_reg;
    assign status.advance    = (speed_reg != '0) &&
                               (fprod_reg >= FPR_W'({intv_reg, 8'b0}));
    assign status.div_last   = (dcnt_reg == '0);

endmodule

@@ src/eased_tween_frame_animator.sv @@
// ----------------------------------------------------------------------------
// Paths from input beat to result beat: toggle, reset, unknown requests and
// paused ticks go from decode straight to publish; a frame tick that does not
// advance stops after the interval check; a tween tick runs the tween chain;
// a frame advance adds the remainder unit. One item in flight: the next beat
// is not taken until the result is registered. Reset (aresetn low,
// synchronous) restores register defaults, clears state and sets playing.
// ----------------------------------------------------------------------------
// eased_tween_frame_animator
// One animation channel: frame stepping or cosine-eased tween between two
// signed Q15.8 values, driven by a stream of tick and control requests.
// ----------------------------------------------------------------------------
//
// Timing of the work per item:
//   - The tween path runs a fixed chain of shared arithmetic steps: the
//     delta * speed product, a reciprocal multiply by 1/125 with a single
//     compare-and-subtract correction, the table position product, two
//     reads of the ease table over one read port, the interpolation
//     multiply and finally the start/end blend multiply with rounding.
//   - The frame path multiplies elapsed time by speed, compares it with the
//     frame interval and, on an advance, takes (index + 1) mod count through a
//     bit-serial restoring remainder unit, one bit per cycle.
// The ease table is a constant array built at elaboration, so there is no
// fill pass after reset.
module eased_tween_frame_animator
    import eta_pkg::*;
#(
    parameter int EASE_TABLE_DEPTH = DEF_EASE_TABLE_DEPTH,
    parameter int MAX_FRAMES       = DEF_MAX_FRAMES
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port, register index per the list of registers
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    // request beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // time_ms[31:0], delta_ms[47:32]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // req_type[1:0]

    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // value[23:0], frame[31:24],
                                             // playing[32], progress[49:33],
                                             // zero pad [55:50]
);

    cmd_t    cmd;
    status_t status;

    // Sequencer: accept a beat in idle, walk the chosen path, hold the result
    // until the output register is free, then advance back to idle.
    eta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: register file, channel state, shared multipliers, remainder
    // unit, ease table and the registered result word.
    eta_datapath #(
        .EASE_TABLE_DEPTH (EASE_TABLE_DEPTH),
        .MAX_FRAMES       (MAX_FRAMES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tdata      (m_tdata),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
